@@ rtl/core/cvtp_pkg.sv @@
// Shared types, widths and helper functions of the trajectory predictor.
`default_nettype none

package cvtp_pkg;

    // Field widths.
    localparam int POS_W   = 24;
    localparam int ANG_W   = 16;
    localparam int VEL_W   = 16;
    localparam int TS_W    = 12;
    localparam int STEP_W  = 6;
    localparam int TIME_W  = 18;
    localparam int RANGE_W = 10;
    localparam int CFG_W   = 12;

    // Internal arithmetic widths.
    localparam int DIFF_W = POS_W + 1;          // obstacle minus ego
    localparam int SQ_W   = 2 * POS_W;          // one squared difference
    localparam int DIST_W = SQ_W + 1;           // sum of two squares
    localparam int R2_W   = 2 * RANGE_W;        // detection range squared
    localparam int INC_W  = VEL_W + TS_W + 1;   // rate times time step
    localparam int ACC_W  = 34;                 // rate times elapsed time
    localparam int FRAC_W = 12;                 // fraction bits of time
    localparam int SUM_W  = POS_W + 1;          // pose before saturation

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MODEL_ENABLE = 2'd0,
        CFG_STEP_PERIOD  = 2'd1,
        CFG_STEP_COUNT   = 2'd2,
        CFG_GATE_RADIUS  = 2'd3
    } cfg_index_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming request
        logic diff;     // form differences and per-step increments
        logic square;   // square the differences and the range
        logic start;    // clear the step counters for a new trajectory
        logic emit;     // load the next pose into the output register
    } cvtp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gate_pass;    // obstacle lies within the detection range
        logic out_free;     // output register can take a pose this cycle
        logic last_step;    // the pose about to be emitted is the final one
    } cvtp_status_t;

    // Clamp a 25-bit signed sum to 24 signed bits.
    function automatic logic signed [POS_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
        logic signed [POS_W-1:0] r;
        begin
            if (v[SUM_W-1] != v[SUM_W-2])
            begin
                r = v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
            end
            else
            begin
                r = v[POS_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cvtp_ctrl.sv @@
// Controller state machine of the trajectory predictor.
`default_nettype none

module cvtp_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  model_enable,
    input  wire cvtp_pkg::cvtp_status_t status,
    output cvtp_pkg::cvtp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_GATE,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                // A request taken while the model is disabled is dropped.
                if (in_valid && model_enable)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_GATE;
            end
            ST_GATE:
            begin
                cmd.start  = 1'b1;
                state_next = status.gate_pass ? ST_RUN : ST_IDLE;
            end
            ST_RUN:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_step)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cvtp_dpath.sv @@
// Datapath of the trajectory predictor: range gate, step accumulators, output register.
`default_nettype none

module cvtp_dpath (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire cvtp_pkg::cvtp_cmd_t                     cmd,
    output cvtp_pkg::cvtp_status_t                       status,
    input  wire logic        [cvtp_pkg::TS_W-1:0]        step_period,
    input  wire logic        [cvtp_pkg::STEP_W-1:0]      step_count,
    input  wire logic        [cvtp_pkg::RANGE_W-1:0]     gate_radius,
    input  wire logic signed [cvtp_pkg::POS_W-1:0]       ego_x,
    input  wire logic signed [cvtp_pkg::POS_W-1:0]       ego_y,
    input  wire logic signed [cvtp_pkg::POS_W-1:0]       obstacle_x,
    input  wire logic signed [cvtp_pkg::POS_W-1:0]       obstacle_y,
    input  wire logic signed [cvtp_pkg::ANG_W-1:0]       obstacle_heading,
    input  wire logic signed [cvtp_pkg::VEL_W-1:0]       vel_x,
    input  wire logic signed [cvtp_pkg::VEL_W-1:0]       vel_y,
    input  wire logic signed [cvtp_pkg::ANG_W-1:0]       yaw_rate,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic             [cvtp_pkg::STEP_W-1:0]      step_index,
    output logic             [cvtp_pkg::TIME_W-1:0]      elapsed_time,
    output logic signed      [cvtp_pkg::POS_W-1:0]       pred_x,
    output logic signed      [cvtp_pkg::POS_W-1:0]       pred_y,
    output logic signed      [cvtp_pkg::POS_W-1:0]       pred_heading,
    output logic                                         last_pose
);

    // Latched request.
    logic signed [cvtp_pkg::POS_W-1:0] ego_x_reg;
    logic signed [cvtp_pkg::POS_W-1:0] ego_y_reg;
    logic signed [cvtp_pkg::POS_W-1:0] obs_x_reg;
    logic signed [cvtp_pkg::POS_W-1:0] obs_y_reg;
    logic signed [cvtp_pkg::ANG_W-1:0] obs_h_reg;
    logic signed [cvtp_pkg::VEL_W-1:0] vel_x_reg;
    logic signed [cvtp_pkg::VEL_W-1:0] vel_y_reg;
    logic signed [cvtp_pkg::ANG_W-1:0] yaw_rate_reg;

    // Range gate.
    logic signed [cvtp_pkg::DIFF_W-1:0]  dx_reg;
    logic signed [cvtp_pkg::DIFF_W-1:0]  dy_reg;
    logic signed [2*cvtp_pkg::DIFF_W-1:0] dx_sq;
    logic signed [2*cvtp_pkg::DIFF_W-1:0] dy_sq;
    logic        [cvtp_pkg::SQ_W-1:0]    dx2_reg;
    logic        [cvtp_pkg::SQ_W-1:0]    dy2_reg;
    logic        [cvtp_pkg::R2_W-1:0]    r2_reg;
    logic        [cvtp_pkg::DIST_W-1:0]  dist2;
    logic        [cvtp_pkg::DIST_W-1:0]  limit2;

    // Per-step increments and running products.
    logic signed [cvtp_pkg::INC_W-1:0] inc_x_reg;
    logic signed [cvtp_pkg::INC_W-1:0] inc_y_reg;
    logic signed [cvtp_pkg::INC_W-1:0] inc_h_reg;
    logic signed [cvtp_pkg::ACC_W-1:0] acc_x_reg;
    logic signed [cvtp_pkg::ACC_W-1:0] acc_y_reg;
    logic signed [cvtp_pkg::ACC_W-1:0] acc_h_reg;
    logic        [cvtp_pkg::TIME_W-1:0] t_reg;
    logic        [cvtp_pkg::TS_W-1:0]   ts_reg;
    logic        [cvtp_pkg::STEP_W-1:0] idx_reg;
    logic        [cvtp_pkg::STEP_W-1:0] n_reg;

    // Pose of the current step.
    logic signed [cvtp_pkg::SUM_W-1:0] sum_x;
    logic signed [cvtp_pkg::SUM_W-1:0] sum_y;
    logic signed [cvtp_pkg::SUM_W-1:0] sum_h;

    // Output register.
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic        [cvtp_pkg::STEP_W-1:0] step_index_reg;
    logic        [cvtp_pkg::TIME_W-1:0] elapsed_time_reg;
    logic signed [cvtp_pkg::POS_W-1:0]  pred_x_reg;
    logic signed [cvtp_pkg::POS_W-1:0]  pred_y_reg;
    logic signed [cvtp_pkg::POS_W-1:0]  pred_heading_reg;
    logic                               last_pose_reg;

    // Squares of the differences and the gate comparison.
    assign dx_sq  = dx_reg * dx_reg;
    assign dy_sq  = dy_reg * dy_reg;
    assign dist2  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign limit2 = {{(cvtp_pkg::DIST_W-cvtp_pkg::R2_W-16){1'b0}}, r2_reg, 16'b0};

    // Floored product added to the base value; the arithmetic shift floors.
    assign sum_x = {obs_x_reg[cvtp_pkg::POS_W-1], obs_x_reg}
                 + {{3{acc_x_reg[cvtp_pkg::ACC_W-1]}},
                    acc_x_reg[cvtp_pkg::ACC_W-1:cvtp_pkg::FRAC_W]};
    assign sum_y = {obs_y_reg[cvtp_pkg::POS_W-1], obs_y_reg}
                 + {{3{acc_y_reg[cvtp_pkg::ACC_W-1]}},
                    acc_y_reg[cvtp_pkg::ACC_W-1:cvtp_pkg::FRAC_W]};
    assign sum_h = {{(cvtp_pkg::SUM_W-cvtp_pkg::ANG_W){obs_h_reg[cvtp_pkg::ANG_W-1]}}, obs_h_reg}
                 + {{3{acc_h_reg[cvtp_pkg::ACC_W-1]}},
                    acc_h_reg[cvtp_pkg::ACC_W-1:cvtp_pkg::FRAC_W]};

    // Status toward the controller.
    assign status.gate_pass = (dist2 <= limit2);
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.last_step = (idx_reg == n_reg);

    // Payload registers of the request, the gate and the step accumulators.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ego_x_reg    <= ego_x;
            ego_y_reg    <= ego_y;
            obs_x_reg    <= obstacle_x;
            obs_y_reg    <= obstacle_y;
            obs_h_reg    <= obstacle_heading;
            vel_x_reg    <= vel_x;
            vel_y_reg    <= vel_y;
            yaw_rate_reg <= yaw_rate;
        end
        if (cmd.diff)
        begin
            dx_reg    <= {obs_x_reg[cvtp_pkg::POS_W-1], obs_x_reg}
                       - {ego_x_reg[cvtp_pkg::POS_W-1], ego_x_reg};
            dy_reg    <= {obs_y_reg[cvtp_pkg::POS_W-1], obs_y_reg}
                       - {ego_y_reg[cvtp_pkg::POS_W-1], ego_y_reg};
            inc_x_reg <= cvtp_pkg::INC_W'(vel_x_reg * signed'({1'b0, step_period}));
            inc_y_reg <= cvtp_pkg::INC_W'(vel_y_reg * signed'({1'b0, step_period}));
            inc_h_reg <= cvtp_pkg::INC_W'(yaw_rate_reg * signed'({1'b0, step_period}));
            ts_reg    <= step_period;
        end
        if (cmd.square)
        begin
            dx2_reg <= dx_sq[cvtp_pkg::SQ_W-1:0];
            dy2_reg <= dy_sq[cvtp_pkg::SQ_W-1:0];
            r2_reg  <= cvtp_pkg::R2_W'(gate_radius) * cvtp_pkg::R2_W'(gate_radius);
        end
        if (cmd.start)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_h_reg <= '0;
            t_reg     <= '0;
            idx_reg   <= '0;
            n_reg     <= step_count;
        end
        else if (cmd.emit)
        begin
            acc_x_reg <= acc_x_reg + cvtp_pkg::ACC_W'(inc_x_reg);
            acc_y_reg <= acc_y_reg + cvtp_pkg::ACC_W'(inc_y_reg);
            acc_h_reg <= acc_h_reg + cvtp_pkg::ACC_W'(inc_h_reg);
            t_reg     <= t_reg + cvtp_pkg::TIME_W'(ts_reg);
            idx_reg   <= idx_reg + 1'b1;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            step_index_reg   <= idx_reg;
            elapsed_time_reg <= t_reg;
            pred_x_reg       <= cvtp_pkg::sat24(sum_x);
            pred_y_reg       <= cvtp_pkg::sat24(sum_y);
            pred_heading_reg <= cvtp_pkg::sat24(sum_h);
            last_pose_reg    <= status.last_step;
        end
    end

    // Output valid: set on a new pose, cleared when the pose is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign step_index   = step_index_reg;
    assign elapsed_time = elapsed_time_reg;
    assign pred_x       = pred_x_reg;
    assign pred_y       = pred_y_reg;
    assign pred_heading = pred_heading_reg;
    assign last_pose    = last_pose_reg;

endmodule

`default_nettype wire

@@ rtl/core/constant_velocity_trajectory_predictor_unit.sv @@
// Top level of the constant-velocity trajectory predictor with its configuration registers.
// The first pose of an obstacle follows its request through the diff, square, gate and run states.
// Throughput: step_count+1 poses follow one per cycle while out_ready stays high, and no new
// request is taken until the last one is emitted; a gated or disabled obstacle yields no pose.
// The running products are kept by one accumulator each for x, y and heading, stepped once per pose.
// Reset: asynchronous, active low; the controller returns to idle, no pose is pending, and
// the registers take model enable 1, step period 410, step count 30, gate radius 50.
`default_nettype none

module constant_velocity_trajectory_predictor_unit (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    cfg_we,
    input  wire logic        [1:0]                       cfg_index,
    input  wire logic        [cvtp_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic signed [cvtp_pkg::POS_W-1:0]       ego_x,
    input  wire logic signed [cvtp_pkg::POS_W-1:0]       ego_y,
    input  wire logic signed [cvtp_pkg::POS_W-1:0]       obstacle_x,
    input  wire logic signed [cvtp_pkg::POS_W-1:0]       obstacle_y,
    input  wire logic signed [cvtp_pkg::ANG_W-1:0]       obstacle_heading,
    input  wire logic signed [cvtp_pkg::VEL_W-1:0]       vel_x,
    input  wire logic signed [cvtp_pkg::VEL_W-1:0]       vel_y,
    input  wire logic signed [cvtp_pkg::ANG_W-1:0]       yaw_rate,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic             [cvtp_pkg::STEP_W-1:0]      step_index,
    output logic             [cvtp_pkg::TIME_W-1:0]      elapsed_time,
    output logic signed      [cvtp_pkg::POS_W-1:0]       pred_x,
    output logic signed      [cvtp_pkg::POS_W-1:0]       pred_y,
    output logic signed      [cvtp_pkg::POS_W-1:0]       pred_heading,
    output logic                                         last_pose
);

    logic                             model_enable_reg;
    logic [cvtp_pkg::TS_W-1:0]        step_period_reg;
    logic [cvtp_pkg::STEP_W-1:0]      step_count_reg;
    logic [cvtp_pkg::RANGE_W-1:0]     gate_radius_reg;
    cvtp_pkg::cfg_index_t             cfg_code;
    cvtp_pkg::cvtp_cmd_t              cmd;
    cvtp_pkg::cvtp_status_t           status;

    assign cfg_code = cvtp_pkg::cfg_index_t'(cfg_index);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_enable_reg <= 1'b1;
            step_period_reg  <= cvtp_pkg::TS_W'(410);
            step_count_reg   <= cvtp_pkg::STEP_W'(30);
            gate_radius_reg  <= cvtp_pkg::RANGE_W'(50);
        end
        else if (cfg_we)
        begin
            unique case (cfg_code)
                cvtp_pkg::CFG_MODEL_ENABLE:
                begin
                    model_enable_reg <= cfg_wdata[0];
                end
                cvtp_pkg::CFG_STEP_PERIOD:
                begin
                    step_period_reg <= cfg_wdata[cvtp_pkg::TS_W-1:0];
                end
                cvtp_pkg::CFG_STEP_COUNT:
                begin
                    step_count_reg <= cfg_wdata[cvtp_pkg::STEP_W-1:0];
                end
                cvtp_pkg::CFG_GATE_RADIUS:
                begin
                    gate_radius_reg <= cfg_wdata[cvtp_pkg::RANGE_W-1:0];
                end
                default:
                begin
                    model_enable_reg <= model_enable_reg;
                end
            endcase
        end
    end

    // Controller.
    cvtp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .model_enable (model_enable_reg),
        .status       (status),
        .cmd          (cmd)
    );

    // Datapath.
    cvtp_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .step_period      (step_period_reg),
        .step_count       (step_count_reg),
        .gate_radius      (gate_radius_reg),
        .ego_x            (ego_x),
        .ego_y            (ego_y),
        .obstacle_x       (obstacle_x),
        .obstacle_y       (obstacle_y),
        .obstacle_heading (obstacle_heading),
        .vel_x            (vel_x),
        .vel_y            (vel_y),
        .yaw_rate         (yaw_rate),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .step_index       (step_index),
        .elapsed_time     (elapsed_time),
        .pred_x           (pred_x),
        .pred_y           (pred_y),
        .pred_heading     (pred_heading),
        .last_pose        (last_pose)
    );

endmodule

`default_nettype wire

@@ rtl/core/cvtp_checker.sv @@
// Port-level checker of the trajectory predictor and its bind to the top level.
`default_nettype none

module cvtp_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_ready,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic        [cvtp_pkg::STEP_W-1:0] step_index,
    input wire logic        [cvtp_pkg::TIME_W-1:0] elapsed_time,
    input wire logic signed [cvtp_pkg::POS_W-1:0]  pred_x,
    input wire logic                               last_pose
);

    // A stalled pose holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pred_x) && $stable(step_index))
        else $error("stalled pose changed");

    // Poses of one trajectory follow without a gap, with rising step index.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_pose |=> out_valid
            && step_index == cvtp_pkg::STEP_W'($past(step_index) + 1'b1))
        else $error("gap or skipped index inside a trajectory");

    // No new request is taken while a trajectory is still being produced.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_pose |-> !in_ready)
        else $error("request taken during a trajectory");

    // The first pose sits at zero elapsed time.
    a_first_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_index == '0 |-> elapsed_time == '0)
        else $error("first pose with nonzero time");

endmodule

bind constant_velocity_trajectory_predictor_unit cvtp_checker u_cvtp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .step_index   (step_index),
    .elapsed_time (elapsed_time),
    .pred_x       (pred_x),
    .last_pose    (last_pose)
);

`default_nettype wire
